[sv/stpm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpm_pkg: shared constants for the seed tube pulse monitor
// Field widths, register indexes, reset values and limit arithmetic constants.
// ----------------------------------------------------------------------------
package stpm_pkg;

    // Field widths
    localparam int LEVEL_W   = 6;
    localparam int CNT_W     = 16;
    localparam int TURN_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // Default channel count; contact inputs exist for LEVEL_W channels only
    localparam int DEFAULT_CHANNELS = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP        = 1'd1;

    // Reset values
    localparam logic [CNT_W-1:0] INIT_PERIOD_RST = 16'd200;
    localparam logic [CNT_W-1:0] MIN_GAP_RST     = 16'd2;
    localparam logic [CNT_W-1:0] PERIOD_UNKNOWN  = 16'hFFFF;

    // Limit is floor(LIMIT_NUM * period / LIMIT_DEN), compared without a divide:
    //   sum <= limit  <=>  LIMIT_DEN * sum <= LIMIT_NUM * period
    //   sum >= limit  <=>  LIMIT_DEN * sum + LIMIT_DEN > LIMIT_NUM * period
    localparam int CMP_W     = 20;
    localparam int LIMIT_NUM = 13;
    localparam int LIMIT_DEN = 10;

    typedef logic [CNT_W-1:0] cnt_t;

endpackage : stpm_pkg
`default_nettype wire

[sv/stpm_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpm_in_if: input channel of the pulse monitor
// Valid/ready channel carrying the command bit and the contact sample.
// ----------------------------------------------------------------------------
interface stpm_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [stpm_pkg::LEVEL_W-1:0]  contact_levels;

    modport source (output valid, output func, output contact_levels, input ready);
    modport sink   (input valid, input func, input contact_levels, output ready);
endinterface : stpm_in_if
`default_nettype wire

[sv/stpm_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpm_out_if: result channel of the pulse monitor
// Valid/ready channel carrying health mask, last period and turn count.
// ----------------------------------------------------------------------------
interface stpm_out_if;
    logic                          valid;
    logic                          ready;
    logic [stpm_pkg::LEVEL_W-1:0]  healthy_mask;
    logic [stpm_pkg::CNT_W-1:0]    last_period;
    logic [stpm_pkg::TURN_W-1:0]   turn_count;

    modport source (output valid, output healthy_mask, output last_period,
                    output turn_count, input ready);
    modport sink   (input valid, input healthy_mask, input last_period,
                    input turn_count, output ready);
endinterface : stpm_out_if
`default_nettype wire

[sv/seed_tube_pulse_monitor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seed_tube_pulse_monitor: per-tick pulse period and health tracking
// Tick: the sequencer takes each channel through two passes (contact,
//   timeout) through one shared limit comparator, then loads the result in
//   the done state once the output register is free.
// Clear: zeroes the turn count and goes straight to the done state. One item
//   at a time; the next transfer is taken as soon as the result is in the
//   output register, even if it is not yet taken.
// Reset (rst_n, async low): counters and health zero, period unknown,
//   registers at initial_period 200 and min_gap 2.
// ----------------------------------------------------------------------------
module seed_tube_pulse_monitor #(
    parameter int CHANNELS = stpm_pkg::DEFAULT_CHANNELS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [stpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [stpm_pkg::CFG_DAT_W-1:0]  cfg_data,
    stpm_in_if.sink                              in_ch,
    stpm_out_if.source                           out_ch
);
    import stpm_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHK_A = 2'd1;   // contact pass
    localparam logic [1:0] ST_CHK_B = 2'd2;   // timeout pass
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [LEVEL_W-1:0]  levels_reg, levels_next;

    cnt_t                init_period_reg, init_period_next;
    cnt_t                min_gap_reg, min_gap_next;

    cnt_t                gap_reg  [CHANNELS];
    cnt_t                gap_next [CHANNELS];
    cnt_t                hold_reg  [CHANNELS];
    cnt_t                hold_next [CHANNELS];
    cnt_t                exp_reg, exp_next;
    cnt_t                period_reg, period_next;
    logic [CHANNELS-1:0] health_reg, health_next;
    logic [TURN_W-1:0]   turns_reg, turns_next;

    logic                out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]  mask_reg, mask_next;
    cnt_t                last_period_reg, last_period_next;
    logic [TURN_W-1:0]   turn_count_reg, turn_count_next;

    // Closed contact per channel; channels without an input read as open
    logic [CHANNELS-1:0] closed_vec;
    logic [LEVEL_W-1:0]  health_view;

    for (genvar k = 0; k < CHANNELS; k++) begin : g_closed
        if (k < LEVEL_W) begin : g_in
            assign closed_vec[k] = ~levels_reg[k];
        end else begin : g_none
            assign closed_vec[k] = 1'b0;
        end
    end

    for (genvar k = 0; k < LEVEL_W; k++) begin : g_view
        if (k < CHANNELS) begin : g_in
            assign health_view[k] = health_next[k];
        end else begin : g_none
            assign health_view[k] = 1'b0;
        end
    end

    // Shared limit comparator: LIMIT_DEN*sum (+LIMIT_DEN on timeout pass)
    // against LIMIT_NUM*expected_period
    cnt_t             gap_cur, hold_cur, cmp_sum;
    logic [CMP_W-1:0] cmp_lhs, cmp_rhs;
    logic             cmp_gt;

    assign gap_cur  = gap_reg[ch_reg];
    assign hold_cur = hold_reg[ch_reg];
    assign cmp_sum  = gap_cur + hold_cur;
    assign cmp_lhs  = CMP_W'(cmp_sum) * CMP_W'(LIMIT_DEN)
                    + ((state_reg == ST_CHK_B) ? CMP_W'(LIMIT_DEN) : CMP_W'(0));
    assign cmp_rhs  = CMP_W'(exp_reg) * CMP_W'(LIMIT_NUM);
    assign cmp_gt   = cmp_lhs > cmp_rhs;

    logic accept_in;
    logic pulse_ok;

    assign accept_in = in_ch.valid && in_ch.ready;
    assign pulse_ok  = closed_vec[ch_reg] && (gap_cur > min_gap_reg) && !cmp_gt;

    // Next-state logic
    always_comb
    begin
        state_next       = state_reg;
        ch_next          = ch_reg;
        levels_next      = levels_reg;
        init_period_next = init_period_reg;
        min_gap_next     = min_gap_reg;
        gap_next         = gap_reg;
        hold_next        = hold_reg;
        exp_next         = exp_reg;
        period_next      = period_reg;
        health_next      = health_reg;
        turns_next       = turns_reg;
        out_valid_next   = out_valid_reg;
        mask_next        = mask_reg;
        last_period_next = last_period_reg;
        turn_count_next  = turn_count_reg;

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                REG_INITIAL_PERIOD: init_period_next = cfg_data;
                REG_MIN_GAP:        min_gap_next     = cfg_data;
                default:            ;
            endcase
        end

        // output register drains on transfer
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    levels_next = in_ch.contact_levels;
                    ch_next     = '0;
                    if (in_ch.func)
                    begin
                        turns_next = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (health_reg == '0)
                        begin
                            exp_next    = init_period_reg;
                            period_next = PERIOD_UNKNOWN;
                        end
                        state_next = ST_CHK_A;
                    end
                end
            end

            ST_CHK_A:
            begin
                if (closed_vec[ch_reg])
                begin
                    if (pulse_ok)
                    begin
                        turns_next          = turns_reg + 1'b1;
                        exp_next            = cmp_sum;
                        period_next         = cmp_sum;
                        health_next[ch_reg] = 1'b1;
                        hold_next[ch_reg]   = CNT_W'(1);
                    end
                    else
                    begin
                        hold_next[ch_reg] = hold_cur + 1'b1;
                    end
                    gap_next[ch_reg] = '0;
                end
                state_next = ST_CHK_B;
            end

            ST_CHK_B:
            begin
                if (cmp_gt)
                begin
                    health_next[ch_reg] = 1'b0;
                    hold_next[ch_reg]   = '0;
                end
                else
                begin
                    gap_next[ch_reg] = gap_cur + 1'b1;
                end
                if (ch_reg == CH_W'(CHANNELS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_CHK_A;
                end
            end

            ST_DONE:
            begin
                // load result once the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next   = 1'b1;
                    mask_next        = health_view;
                    last_period_next = period_reg;
                    turn_count_next  = turns_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ch_reg          <= '0;
            init_period_reg <= INIT_PERIOD_RST;
            min_gap_reg     <= MIN_GAP_RST;
            for (int k = 0; k < CHANNELS; k++)
            begin
                gap_reg[k]  <= '0;
                hold_reg[k] <= '0;
            end
            exp_reg         <= '0;
            period_reg      <= PERIOD_UNKNOWN;
            health_reg      <= '0;
            turns_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ch_reg          <= ch_next;
            init_period_reg <= init_period_next;
            min_gap_reg     <= min_gap_next;
            gap_reg         <= gap_next;
            hold_reg        <= hold_next;
            exp_reg         <= exp_next;
            period_reg      <= period_next;
            health_reg      <= health_next;
            turns_reg       <= turns_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        levels_reg      <= levels_next;
        mask_reg        <= mask_next;
        last_period_reg <= last_period_next;
        turn_count_reg  <= turn_count_next;
    end

    assign in_ch.ready         = (state_reg == ST_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.healthy_mask = mask_reg;
    assign out_ch.last_period  = last_period_reg;
    assign out_ch.turn_count   = turn_count_reg;

endmodule : seed_tube_pulse_monitor
`default_nettype wire
